[design/battery_discharge_rate_learner_assert.svh]
// Assertion macros for the battery discharge rate learner.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BATTERY_DISCHARGE_RATE_LEARNER_ASSERT_SVH
`define BATTERY_DISCHARGE_RATE_LEARNER_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define BDRL_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define BDRL_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BDRL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/bdrl_pkg.sv]
// Shared types and constants for the battery discharge rate learner.
// No dependencies; used by the interfaces, the divider and the top level.
package bdrl_pkg;

  localparam int DT_W       = 20;
  localparam int PCT_W      = 8;
  localparam int BASE_W     = 7;
  localparam int LT_W       = 42;
  localparam int SECS_W     = 32;
  localparam int RATE_W     = 17;
  localparam int REMAIN_W   = 29;
  localparam int MIN_W      = 17;
  localparam int REFR_W     = 17;
  localparam int REBASE_W   = 18;
  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int HOUR_W     = 22;
  localparam int PROD_W     = 29;
  localparam int DIV_NUM_W  = 42;
  localparam int DIV_DEN_W  = 32;
  localparam int DIV_CNT_W  = 6;

  localparam logic [LT_W-1:0]      LT_MAX       = '1;
  localparam logic [DT_W-1:0]      GAP_LIMIT_MS = 20'd600000;
  localparam logic [RATE_W-1:0]    RATE_LIMIT   = 17'd100000;
  localparam logic [HOUR_W-1:0]    MS_PER_HOUR  = 22'd3600000;
  localparam logic [DIV_DEN_W-1:0] MS_PER_SEC   = 32'd1000;
  localparam logic [PCT_W-1:0]     PCT_MIN      = 8'd1;
  localparam logic [PCT_W-1:0]     PCT_MAX      = 8'd100;

  localparam logic [DIV_CNT_W-1:0] DIV_BITS_SECS = 6'd42;
  localparam logic [DIV_CNT_W-1:0] DIV_BITS_PROD = 6'd29;

  localparam logic [MIN_W-1:0]    MIN_LEARN_RST   = 17'd3600;
  localparam logic [REFR_W-1:0]   REFRESH_RST     = 17'd1800;
  localparam logic [REBASE_W-1:0] REBASE_RST      = 18'd10800;
  localparam logic [BASE_W-1:0]   REBASE_DROP_RST = 7'd5;
  localparam logic [BASE_W-1:0]   JUMP_LIMIT_RST  = 7'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LEARN   = 3'd0,
    CFG_REFRESH     = 3'd1,
    CFG_REBASE      = 3'd2,
    CFG_REBASE_DROP = 3'd3,
    CFG_JUMP_LIMIT  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_SECS,
    ST_CHK,
    ST_OBS,
    ST_FIN,
    ST_REM,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

[design/bdrl_if.sv]
// Input and result channel interfaces for the battery discharge rate learner.
// Depends on bdrl_pkg for field widths.
interface bdrl_in_if;
  logic                         valid;
  logic                         ready;
  logic [bdrl_pkg::DT_W-1:0]    elapsed_ms;
  logic                         battery_present;
  logic [bdrl_pkg::PCT_W-1:0]   charge_percent;
  logic                         external_power;

  modport source (output valid, elapsed_ms, battery_present, charge_percent,
                  external_power, input ready);
  modport sink   (input valid, elapsed_ms, battery_present, charge_percent,
                  external_power, output ready);
endinterface

interface bdrl_out_if;
  logic                           valid;
  logic                           ready;
  logic [bdrl_pkg::RATE_W-1:0]    rate_mpct_per_hour;
  logic                           estimate_ready;
  logic [bdrl_pkg::REMAIN_W-1:0]  remaining_secs;
  logic                           learning_active;

  modport source (output valid, rate_mpct_per_hour, estimate_ready, remaining_secs,
                  learning_active, input ready);
  modport sink   (input valid, rate_mpct_per_hour, estimate_ready, remaining_secs,
                  learning_active, output ready);
endinterface

[design/bdrl_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bdrl_pkg; the numerator comes in left-aligned, nbits sets the pass length.
module bdrl_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bdrl_pkg::div_req_t                 req,
  input  logic [bdrl_pkg::DIV_NUM_W-1:0]     num,
  input  logic [bdrl_pkg::DIV_DEN_W-1:0]     den,
  output bdrl_pkg::div_sts_t                 sts,
  output logic [bdrl_pkg::DIV_NUM_W-1:0]     quo
);

  logic                              busy_r;
  logic                              done_r;
  logic [bdrl_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [bdrl_pkg::DIV_NUM_W-1:0]    num_r;
  logic [bdrl_pkg::DIV_NUM_W-1:0]    quo_r;
  logic [bdrl_pkg::DIV_DEN_W-1:0]    den_r;
  logic [bdrl_pkg::DIV_DEN_W-1:0]    rem_r;
  logic [bdrl_pkg::DIV_DEN_W-1:0]    rem_nxt;
  logic [bdrl_pkg::DIV_DEN_W:0]      trial;
  logic [bdrl_pkg::DIV_DEN_W:0]      diff;
  logic                              fits;

  always_comb begin
    trial   = {rem_r, num_r[bdrl_pkg::DIV_NUM_W-1]};
    diff    = trial - {1'b0, den_r};
    fits    = trial >= {1'b0, den_r};
    rem_nxt = fits ? diff[bdrl_pkg::DIV_DEN_W-1:0] : trial[bdrl_pkg::DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == bdrl_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift one numerator bit into the partial remainder each cycle while busy
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[bdrl_pkg::DIV_NUM_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[bdrl_pkg::DIV_NUM_W-2:0], fits};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = quo_r;

endmodule

[design/battery_discharge_rate_learner.sv]
// The bit-serial divider runs up to three passes between input transfer and result
// valid: learning seconds, then the observed rate, then the remaining time, each
// pass only when the tick needs it.
// Ticks are taken one at a time; the next input transfer is taken once
// the result sits in the output register, which may still wait for its own transfer.
// Reset (rst_n low, synchronous): non-payload registers to defaults, rate unknown, rebase armed.
module battery_discharge_rate_learner (
  input  logic                              clk,
  input  logic                              rst_n,
  bdrl_in_if.sink                           in_if,
  bdrl_out_if.source                        out_if,
  input  logic                              cfg_we,
  input  logic [bdrl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bdrl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // configuration registers
  logic [bdrl_pkg::MIN_W-1:0]     min_r;
  logic [bdrl_pkg::REFR_W-1:0]    refresh_r;
  logic [bdrl_pkg::REBASE_W-1:0]  rebase_r;
  logic [bdrl_pkg::BASE_W-1:0]    rdrop_r;
  logic [bdrl_pkg::BASE_W-1:0]    jump_r;

  // latched tick
  logic [bdrl_pkg::DT_W-1:0]      dt_r,      dt_nxt;
  logic                           present_r, present_nxt;
  logic [bdrl_pkg::PCT_W-1:0]     pct_r,     pct_nxt;
  logic                           ext_r,     ext_nxt;

  // learning state
  logic                           bvalid_r,  bvalid_nxt;
  logic                           pend_r,    pend_nxt;
  logic [bdrl_pkg::BASE_W-1:0]    base_r,    base_nxt;
  logic [bdrl_pkg::LT_W-1:0]      lt_r,      lt_nxt;
  logic [bdrl_pkg::BASE_W-1:0]    prev_r,    prev_nxt;
  logic [bdrl_pkg::SECS_W-1:0]    last_r,    last_nxt;
  logic [bdrl_pkg::RATE_W-1:0]    rate_r,    rate_nxt;
  logic [bdrl_pkg::SECS_W-1:0]    secs_r,    secs_nxt;
  logic                           est_r,     est_nxt;
  logic [bdrl_pkg::REMAIN_W-1:0]  remain_r,  remain_nxt;

  // output register
  logic                           out_valid_r, out_valid_nxt;
  logic [bdrl_pkg::RATE_W-1:0]    out_rate_r;
  logic                           out_est_r;
  logic [bdrl_pkg::REMAIN_W-1:0]  out_remain_r;
  logic                           out_active_r;
  logic                           out_load;

  bdrl_pkg::state_t               state_r, state_nxt;

  // divider hookup
  bdrl_pkg::div_req_t                div_req;
  bdrl_pkg::div_sts_t                div_sts;
  logic [bdrl_pkg::DIV_NUM_W-1:0]    div_num;
  logic [bdrl_pkg::DIV_DEN_W-1:0]    div_den;
  logic [bdrl_pkg::DIV_NUM_W-1:0]    div_quo;

  // decision terms
  logic                              in_xfer;
  logic                              emit_free;
  logic                              pct_ok;
  logic                              learn_en;
  logic [bdrl_pkg::PCT_W-1:0]        jump_sum;
  logic                              pre_ext;
  logic                              pre_restart;
  logic                              pre_accum;
  logic [bdrl_pkg::LT_W:0]           lt_sum;
  logic [bdrl_pkg::LT_W-1:0]         lt_new;
  logic [bdrl_pkg::SECS_W-1:0]       secs_w;
  logic                              pct_above;
  logic [bdrl_pkg::BASE_W-1:0]       drop;
  logic                              chk_go;
  logic [bdrl_pkg::PROD_W-1:0]       drop_prod;
  logic [bdrl_pkg::PROD_W-1:0]       pct_prod;
  logic [bdrl_pkg::PROD_W-1:0]       obs_w;
  logic                              obs_ok;
  logic [bdrl_pkg::RATE_W+1:0]       avg_sum;
  logic                              rebase_hit;
  logic                              est_go;

  bdrl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .num   (div_num),
    .den   (div_den),
    .sts   (div_sts),
    .quo   (div_quo)
  );

  assign in_if.ready = (state_r == bdrl_pkg::ST_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign emit_free   = !out_valid_r || out_if.ready;

  // tick qualification: gaps over ten minutes, no battery or a bad percent skip learning
  assign pct_ok   = (pct_r >= bdrl_pkg::PCT_MIN) && (pct_r <= bdrl_pkg::PCT_MAX);
  assign learn_en = (dt_r <= bdrl_pkg::GAP_LIMIT_MS) && present_r && pct_ok;
  assign jump_sum = {1'b0, base_r} + {1'b0, jump_r};

  assign pre_ext     = learn_en && ext_r;
  assign pre_restart = learn_en && !ext_r && (pend_r || !bvalid_r || (pct_r > jump_sum));
  assign pre_accum   = learn_en && !ext_r && !(pend_r || !bvalid_r || (pct_r > jump_sum));

  // saturating learning time
  assign lt_sum = {1'b0, lt_r} + (bdrl_pkg::LT_W+1)'(dt_r);
  assign lt_new = lt_sum[bdrl_pkg::LT_W] ? bdrl_pkg::LT_MAX : lt_sum[bdrl_pkg::LT_W-1:0];

  // seconds saturate at the full 32-bit range
  assign secs_w = (|div_quo[bdrl_pkg::DIV_NUM_W-1:bdrl_pkg::SECS_W]) ? '1
                : div_quo[bdrl_pkg::SECS_W-1:0];

  assign pct_above = pct_r > {1'b0, base_r};
  assign drop      = base_r - pct_r[bdrl_pkg::BASE_W-1:0];
  assign chk_go    = !pct_above && (drop != '0)
                  && (secs_r >= bdrl_pkg::SECS_W'(min_r))
                  && !((drop == prev_r)
                       && ((secs_r - last_r) < bdrl_pkg::SECS_W'(refresh_r)))
                  && (secs_r != '0);

  assign drop_prod = bdrl_pkg::PROD_W'(drop) * bdrl_pkg::PROD_W'(bdrl_pkg::MS_PER_HOUR);
  assign pct_prod  = bdrl_pkg::PROD_W'(pct_r[bdrl_pkg::BASE_W-1:0])
                   * bdrl_pkg::PROD_W'(bdrl_pkg::MS_PER_HOUR);

  assign obs_w   = div_quo[bdrl_pkg::PROD_W-1:0];
  assign obs_ok  = (obs_w != '0) && (obs_w <= bdrl_pkg::PROD_W'(bdrl_pkg::RATE_LIMIT));
  // 3:1 blend of stored and observed rate
  assign avg_sum = (bdrl_pkg::RATE_W+2)'(rate_r) * (bdrl_pkg::RATE_W+2)'(3)
                 + (bdrl_pkg::RATE_W+2)'(obs_w[bdrl_pkg::RATE_W-1:0]);
  assign rebase_hit = (drop >= rdrop_r) && (secs_r >= bdrl_pkg::SECS_W'(rebase_r));

  assign est_go = present_r && !ext_r && pct_ok && (rate_r != '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bdrl_pkg::ST_IDLE: if (in_xfer) state_nxt = bdrl_pkg::ST_PRE;
      bdrl_pkg::ST_PRE:  state_nxt = pre_accum ? bdrl_pkg::ST_SECS : bdrl_pkg::ST_FIN;
      bdrl_pkg::ST_SECS: if (div_sts.done) state_nxt = bdrl_pkg::ST_CHK;
      bdrl_pkg::ST_CHK:  state_nxt = chk_go ? bdrl_pkg::ST_OBS : bdrl_pkg::ST_FIN;
      bdrl_pkg::ST_OBS:  if (div_sts.done) state_nxt = bdrl_pkg::ST_FIN;
      bdrl_pkg::ST_FIN:  state_nxt = est_go ? bdrl_pkg::ST_REM : bdrl_pkg::ST_EMIT;
      bdrl_pkg::ST_REM:  if (div_sts.done) state_nxt = bdrl_pkg::ST_EMIT;
      bdrl_pkg::ST_EMIT: if (emit_free) state_nxt = bdrl_pkg::ST_IDLE;
      default:           state_nxt = bdrl_pkg::ST_IDLE;
    endcase
  end

  // datapath and divider control per state
  always_comb begin
    dt_nxt      = dt_r;
    present_nxt = present_r;
    pct_nxt     = pct_r;
    ext_nxt     = ext_r;
    bvalid_nxt  = bvalid_r;
    pend_nxt    = pend_r;
    base_nxt    = base_r;
    lt_nxt      = lt_r;
    prev_nxt    = prev_r;
    last_nxt    = last_r;
    rate_nxt    = rate_r;
    secs_nxt    = secs_r;
    est_nxt     = est_r;
    remain_nxt  = remain_r;
    div_req     = '0;
    div_num     = '0;
    div_den     = '0;
    out_load    = 1'b0;
    case (state_r)
      bdrl_pkg::ST_IDLE: begin
        if (in_xfer) begin
          dt_nxt      = in_if.elapsed_ms;
          present_nxt = in_if.battery_present;
          pct_nxt     = in_if.charge_percent;
          ext_nxt     = in_if.external_power;
        end
      end
      bdrl_pkg::ST_PRE: begin
        if (pre_ext) begin
          // external power: arm a rebaseline, learn nothing
          pend_nxt = 1'b1;
        end else if (pre_restart) begin
          pend_nxt   = 1'b0;
          bvalid_nxt = 1'b1;
          base_nxt   = pct_r[bdrl_pkg::BASE_W-1:0];
          lt_nxt     = '0;
          prev_nxt   = '0;
          last_nxt   = '0;
        end else if (pre_accum) begin
          lt_nxt        = lt_new;
          div_req.start = 1'b1;
          div_req.nbits = bdrl_pkg::DIV_BITS_SECS;
          div_num       = lt_new;
          div_den       = bdrl_pkg::MS_PER_SEC;
        end
      end
      bdrl_pkg::ST_SECS: begin
        if (div_sts.done) secs_nxt = secs_w;
      end
      bdrl_pkg::ST_CHK: begin
        if (chk_go) begin
          div_req.start = 1'b1;
          div_req.nbits = bdrl_pkg::DIV_BITS_PROD;
          div_num       = {drop_prod, (bdrl_pkg::DIV_NUM_W-bdrl_pkg::PROD_W)'(0)};
          div_den       = secs_r;
        end
      end
      bdrl_pkg::ST_OBS: begin
        if (div_sts.done && obs_ok) begin
          rate_nxt = (rate_r == '0) ? obs_w[bdrl_pkg::RATE_W-1:0]
                                    : avg_sum[bdrl_pkg::RATE_W+1:2];
          prev_nxt = drop;
          last_nxt = secs_r;
          if (rebase_hit) begin
            // large drop over a long window: start a fresh baseline
            bvalid_nxt = 1'b1;
            base_nxt   = pct_r[bdrl_pkg::BASE_W-1:0];
            lt_nxt     = '0;
            prev_nxt   = '0;
            last_nxt   = '0;
          end
        end
      end
      bdrl_pkg::ST_FIN: begin
        if (est_go) begin
          div_req.start = 1'b1;
          div_req.nbits = bdrl_pkg::DIV_BITS_PROD;
          div_num       = {pct_prod, (bdrl_pkg::DIV_NUM_W-bdrl_pkg::PROD_W)'(0)};
          div_den       = bdrl_pkg::DIV_DEN_W'(rate_r);
        end else begin
          est_nxt    = 1'b0;
          remain_nxt = '0;
        end
      end
      bdrl_pkg::ST_REM: begin
        if (div_sts.done) begin
          est_nxt    = 1'b1;
          remain_nxt = div_quo[bdrl_pkg::REMAIN_W-1:0];
        end
      end
      bdrl_pkg::ST_EMIT: begin
        out_load = emit_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // output register: hold until the result transfer, reload behind it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdrl_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      bvalid_r    <= 1'b0;
      pend_r      <= 1'b1;
      base_r      <= '0;
      lt_r        <= '0;
      prev_r      <= '0;
      last_r      <= '0;
      rate_r      <= '0;
      min_r       <= bdrl_pkg::MIN_LEARN_RST;
      refresh_r   <= bdrl_pkg::REFRESH_RST;
      rebase_r    <= bdrl_pkg::REBASE_RST;
      rdrop_r     <= bdrl_pkg::REBASE_DROP_RST;
      jump_r      <= bdrl_pkg::JUMP_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bvalid_r    <= bvalid_nxt;
      pend_r      <= pend_nxt;
      base_r      <= base_nxt;
      lt_r        <= lt_nxt;
      prev_r      <= prev_nxt;
      last_r      <= last_nxt;
      rate_r      <= rate_nxt;
      if (cfg_we) begin
        case (cfg_index)
          bdrl_pkg::CFG_MIN_LEARN:   min_r     <= cfg_wdata[bdrl_pkg::MIN_W-1:0];
          bdrl_pkg::CFG_REFRESH:     refresh_r <= cfg_wdata[bdrl_pkg::REFR_W-1:0];
          bdrl_pkg::CFG_REBASE:      rebase_r  <= cfg_wdata[bdrl_pkg::REBASE_W-1:0];
          bdrl_pkg::CFG_REBASE_DROP: rdrop_r   <= cfg_wdata[bdrl_pkg::BASE_W-1:0];
          bdrl_pkg::CFG_JUMP_LIMIT:  jump_r    <= cfg_wdata[bdrl_pkg::BASE_W-1:0];
          default:                   min_r     <= min_r;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    dt_r      <= dt_nxt;
    present_r <= present_nxt;
    pct_r     <= pct_nxt;
    ext_r     <= ext_nxt;
    secs_r    <= secs_nxt;
    est_r     <= est_nxt;
    remain_r  <= remain_nxt;
    if (out_load) begin
      out_rate_r   <= rate_r;
      out_est_r    <= est_r;
      out_remain_r <= remain_r;
      out_active_r <= bvalid_r;
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.rate_mpct_per_hour = out_rate_r;
  assign out_if.estimate_ready     = out_est_r;
  assign out_if.remaining_secs     = out_remain_r;
  assign out_if.learning_active    = out_active_r;

  `include "battery_discharge_rate_learner_assert.svh"

  `BDRL_ASSERT_ALWAYS(a_rate_bounded, rate_r <= bdrl_pkg::RATE_LIMIT, "stored rate above limit")
  `BDRL_ASSERT_IMPLY(a_div_idle_at_start, div_req.start, !div_sts.busy, "divider restarted while busy")
  `BDRL_ASSERT_IMPLY(a_base_in_range, bvalid_r, (base_r >= 7'd1) && (base_r <= 7'd100), "baseline percent out of range")
  `BDRL_ASSERT_IMPLY(a_estimate_needs_rate, out_valid_r && out_est_r, out_rate_r != '0, "estimate with unknown rate")
  `BDRL_ASSERT_NEXT(a_emit_loads, (state_r == bdrl_pkg::ST_EMIT) && emit_free, out_valid_r, "result not loaded")

endmodule
